// ===== rtl/ascii_rgb_command_frame_parser_unit_defines.svh =====
// assertion macros for the rgb command frame parser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ASCII_RGB_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define ASCII_RGB_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ARFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arfp assertion failed");

// next-cycle implication, disabled in reset
`define ARFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arfp assertion failed");

`endif

// ===== rtl/arfp_pkg.sv =====
// shared types, constants and run decoding functions of the rgb frame parser
// no dependencies; imported by every module of the block
package arfp_pkg;

    localparam logic [7:0] MAX_FRAME_BYTES  = 8'd200;
    localparam logic [7:0] IDLE_TICKS_RESET = 8'd20;
    localparam logic [7:0] IDLE_MAX         = 8'hFF;

    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       frame_valid;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } out_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } levels_t;

    // per-frame capture state, cleared as one unit
    typedef struct packed {
        logic            overflowed;
        logic [7:0]      byte_position;
        logic [2:0]      letter_seen;
        logic [2:0][7:0] letter_position;
        logic [3:0][7:0] recent_bytes;
        logic [2:0][7:0] before_g_bytes;
        logic [2:0][7:0] before_b_bytes;
    } frame_snap_t;

    function automatic logic run_ok(input logic [7:0] len);
        return (len inside {[8'd1:8'd3]});
    endfunction

    // run[0] is the byte nearest the following letter
    function automatic logic [7:0] run_value(input logic [7:0] len,
                                             input logic [2:0][7:0] run);
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] acc;
        d0  = run[0] - DIGIT_BASE;
        d1  = run[1] - DIGIT_BASE;
        d2  = run[2] - DIGIT_BASE;
        acc = d0;
        if (len >= 8'd2)
        begin
            acc = acc + 8'({d1, 3'b000} + {d1, 1'b0});
        end
        if (len >= 8'd3)
        begin
            acc = acc + 8'({d2, 6'b000000} + {d2, 5'b00000} + {d2, 2'b00});
        end
        return acc;
    endfunction

endpackage

// ===== rtl/arfp_run_decode.sv =====
// end-of-frame decode: frame check and new color levels from the captured runs
// depends on arfp_pkg
module arfp_run_decode
    import arfp_pkg::*;
(
    input  frame_snap_t snap,
    input  levels_t     levels_now,
    output logic        frame_valid,
    output levels_t     levels_new
);

    logic [7:0] len_red;
    logic [7:0] len_green;
    logic [7:0] len_blue;

    assign frame_valid = !snap.overflowed && (snap.recent_bytes[0] == CHAR_STAR);

    assign len_red   = snap.letter_position[CH_GREEN] - snap.letter_position[CH_RED] - 8'd1;
    assign len_green = snap.letter_position[CH_BLUE] - snap.letter_position[CH_GREEN] - 8'd1;
    assign len_blue  = snap.byte_position - snap.letter_position[CH_BLUE] - 8'd2;

    always_comb
    begin
        levels_new = levels_now;
        if (frame_valid)
        begin
            if (snap.letter_seen[CH_RED] && snap.letter_seen[CH_GREEN] && run_ok(len_red))
            begin
                levels_new.red = run_value(len_red, snap.before_g_bytes);
            end
            if (snap.letter_seen[CH_GREEN] && snap.letter_seen[CH_BLUE]
                && run_ok(len_green))
            begin
                levels_new.green = run_value(len_green, snap.before_b_bytes);
            end
            if (snap.letter_seen[CH_BLUE] && run_ok(len_blue))
            begin
                levels_new.blue = run_value(len_blue, snap.recent_bytes[3:1]);
            end
        end
    end

endmodule

// ===== rtl/arfp_frame_core.sv =====
// frame hunting, byte capture, idle timing and color level state
// depends on arfp_pkg and arfp_run_decode
module arfp_frame_core
    import arfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_word_t  word,
    input  logic [7:0] idle_ticks,
    output logic      finish,
    output out_word_t result
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [7:0]  idle_count_reg;
    logic [7:0]  idle_count_next;
    logic [7:0]  idle_inc;
    frame_snap_t snap_reg;
    frame_snap_t snap_next;
    levels_t     levels_reg;
    levels_t     levels_next;
    levels_t     levels_dec;
    logic        dec_valid;
    logic [7:0]  commit_pos;

    arfp_run_decode u_run_decode (
        .snap        (snap_reg),
        .levels_now  (levels_reg),
        .frame_valid (dec_valid),
        .levels_new  (levels_dec)
    );

    assign idle_inc   = (idle_count_reg == IDLE_MAX) ? IDLE_MAX : idle_count_reg + 8'd1;
    assign finish     = (word.mode == MODE_TICK) && in_frame_reg && (idle_inc >= idle_ticks);
    assign commit_pos = snap_reg.byte_position - 8'd1;

    assign result.frame_valid = dec_valid;
    assign result.red_level   = levels_dec.red;
    assign result.green_level = levels_dec.green;
    assign result.blue_level  = levels_dec.blue;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        idle_count_next = idle_count_reg;
        snap_next       = snap_reg;
        levels_next     = levels_reg;
        if (step_en)
        begin
            if (word.mode == MODE_BYTE)
            begin
                if (!in_frame_reg)
                begin
                    if (word.rx_byte == CHAR_R)
                    begin
                        snap_next                 = '0;
                        snap_next.recent_bytes[0] = CHAR_R;
                        snap_next.byte_position   = 8'd1;
                        in_frame_next             = 1'b1;
                        idle_count_next           = '0;
                    end
                end
                else
                begin
                    idle_count_next = '0;
                    if (snap_reg.byte_position >= MAX_FRAME_BYTES)
                    begin
                        snap_next.overflowed = 1'b1;
                    end
                    else
                    begin
                        // classify the byte now leaving the newest slot
                        case (snap_reg.recent_bytes[0])
                            CHAR_R:
                            begin
                                snap_next.letter_position[CH_RED] = commit_pos;
                                snap_next.letter_seen[CH_RED]     = 1'b1;
                            end
                            CHAR_G:
                            begin
                                snap_next.letter_position[CH_GREEN] = commit_pos;
                                snap_next.letter_seen[CH_GREEN]     = 1'b1;
                                snap_next.before_g_bytes = snap_reg.recent_bytes[3:1];
                            end
                            CHAR_B:
                            begin
                                snap_next.letter_position[CH_BLUE] = commit_pos;
                                snap_next.letter_seen[CH_BLUE]     = 1'b1;
                                snap_next.before_b_bytes = snap_reg.recent_bytes[3:1];
                            end
                            default:
                            begin
                            end
                        endcase
                        snap_next.recent_bytes  = {snap_reg.recent_bytes[2:0], word.rx_byte};
                        snap_next.byte_position = snap_reg.byte_position + 8'd1;
                    end
                end
            end
            else if (in_frame_reg)
            begin
                idle_count_next = idle_inc;
                if (finish)
                begin
                    levels_next     = levels_dec;
                    snap_next       = '0;
                    in_frame_next   = 1'b0;
                    idle_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            idle_count_reg <= '0;
            snap_reg       <= '0;
            levels_reg     <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            idle_count_reg <= idle_count_next;
            snap_reg       <= snap_next;
            levels_reg     <= levels_next;
        end
    end

endmodule

// ===== rtl/ascii_rgb_command_frame_parser_unit.sv =====
// top level of the rgb command frame parser: input register, frame core, result register
// depends on arfp_pkg and arfp_frame_core
// Takes one word per clock (a received byte or a timer tick) and returns one result word
// for each frame that ends after idle_ticks idle ticks, through the input register and
// then the result register. A new word can be taken every cycle unless the input stalls,
// since all per-word work is combinational logic between the input register and the
// frame state. The input stalls only while a finished result waits in the result register
// and the held word would end another frame. idle_ticks resets to 20; the user must write
// it through cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
module ascii_rgb_command_frame_parser_unit
    import arfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic       in_valid_reg;
    in_word_t   in_word_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_word_t  out_word_reg;
    logic [7:0] idle_ticks_reg;
    logic       out_free;
    logic       proceed;
    logic       finish;
    out_word_t  result;

    arfp_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (proceed),
        .word       (in_word_reg),
        .idle_ticks (idle_ticks_reg),
        .finish     (finish),
        .result     (result)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign proceed   = in_valid_reg && (!finish || out_free);
    assign in_ready  = !in_valid_reg || proceed;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proceed && finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            idle_ticks_reg <= IDLE_TICKS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                idle_ticks_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (proceed && finish)
        begin
            out_word_reg <= result;
        end
    end

endmodule

// ===== rtl/arfp_checker.sv =====
// port-level checker for the rgb command frame parser, bound to the top level
// depends on arfp_pkg and ascii_rgb_command_frame_parser_unit_defines.svh
`include "ascii_rgb_command_frame_parser_unit_defines.svh"

module arfp_checker
    import arfp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // a stalled result word holds
    `ARFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // input never stalls while the result register is empty
    `ARFP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // a new result follows a word taken into the input register and passed to the result register
    `ARFP_ASSERT_SAME(a_result_has_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind ascii_rgb_command_frame_parser_unit arfp_checker u_arfp_checker (.*);

// ===== tb/tb_top.sv =====
// testbench for ascii_rgb_command_frame_parser_unit: queued byte and tick words,
// a tracking model of the parser state, and per-frame result checking
// depends on arfp_pkg and the rtl of the parser
`timescale 1ns / 1ps

module tb_top;
    import arfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_word;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    in_word_t    pending_words[$];
    out_word_t   expected_frames[$];
    out_word_t   oldest_frame;
    int          words_queued = 0;
    int          words_taken = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    logic        calm;

    // tracked parser state
    logic            in_frm;
    logic [7:0]      pos;
    logic            ovf;
    logic [7:0]      idle_cnt;
    logic [7:0]      idle_lim;
    logic [2:0]      seen;
    logic [2:0][7:0] lpos;
    logic [3:0][7:0] recent;
    logic [2:0][7:0] before_g;
    logic [2:0][7:0] before_b;
    logic [2:0][7:0] level;

    ascii_rgb_command_frame_parser_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] digits_value(input logic [7:0] len,
                                                input logic [2:0][7:0] run);
        int acc;
        acc = int'(run[0]) - int'(DIGIT_BASE);
        if (len >= 8'd2)
        begin
            acc += (int'(run[1]) - int'(DIGIT_BASE)) * 10;
        end
        if (len >= 8'd3)
        begin
            acc += (int'(run[2]) - int'(DIGIT_BASE)) * 100;
        end
        return acc[7:0];
    endfunction

    task automatic clear_frame_state();
        in_frm   = 1'b0;
        pos      = '0;
        ovf      = 1'b0;
        idle_cnt = '0;
        seen     = '0;
        lpos     = '0;
        recent   = '0;
        before_g = '0;
        before_b = '0;
    endtask

    task automatic track_word(input in_word_t w);
        logic [7:0] run_len;
        out_word_t  res;
        if (w.mode == MODE_BYTE)
        begin
            if (!in_frm)
            begin
                if (w.rx_byte == CHAR_R)
                begin
                    clear_frame_state();
                    in_frm    = 1'b1;
                    recent[0] = w.rx_byte;
                    pos       = 8'd1;
                end
            end
            else
            begin
                idle_cnt = '0;
                if (pos >= MAX_FRAME_BYTES)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    // classify the byte that is now one behind
                    case (recent[0])
                        CHAR_R:
                        begin
                            lpos[CH_RED] = pos - 8'd1;
                            seen[CH_RED] = 1'b1;
                        end
                        CHAR_G:
                        begin
                            lpos[CH_GREEN] = pos - 8'd1;
                            seen[CH_GREEN] = 1'b1;
                            before_g       = recent[3:1];
                        end
                        CHAR_B:
                        begin
                            lpos[CH_BLUE] = pos - 8'd1;
                            seen[CH_BLUE] = 1'b1;
                            before_b      = recent[3:1];
                        end
                        default:
                        begin
                        end
                    endcase
                    recent = {recent[2:0], w.rx_byte};
                    pos    = pos + 8'd1;
                end
            end
        end
        else if (in_frm)
        begin
            if (idle_cnt != IDLE_MAX)
            begin
                idle_cnt = idle_cnt + 8'd1;
            end
            if (idle_cnt >= idle_lim)
            begin
                res.frame_valid = !ovf && (recent[0] == CHAR_STAR);
                if (res.frame_valid)
                begin
                    if (seen[CH_RED] && seen[CH_GREEN])
                    begin
                        run_len = lpos[CH_GREEN] - lpos[CH_RED] - 8'd1;
                        if (run_len inside {[8'd1:8'd3]})
                        begin
                            level[CH_RED] = digits_value(run_len, before_g);
                        end
                    end
                    if (seen[CH_GREEN] && seen[CH_BLUE])
                    begin
                        run_len = lpos[CH_BLUE] - lpos[CH_GREEN] - 8'd1;
                        if (run_len inside {[8'd1:8'd3]})
                        begin
                            level[CH_GREEN] = digits_value(run_len, before_b);
                        end
                    end
                    if (seen[CH_BLUE])
                    begin
                        run_len = pos - lpos[CH_BLUE] - 8'd2;
                        if (run_len inside {[8'd1:8'd3]})
                        begin
                            level[CH_BLUE] = digits_value(run_len, recent[3:1]);
                        end
                    end
                end
                res.red_level   = level[CH_RED];
                res.green_level = level[CH_GREEN];
                res.blue_level  = level[CH_BLUE];
                expected_frames.push_back(res);
                clear_frame_state();
            end
        end
    endtask

    initial
    begin
        clear_frame_state();
        level    = '0;
        idle_lim = IDLE_TICKS_RESET;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_word(in_word);
                words_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 32))
                begin
                    in_valid <= 1'b1;
                    in_word  <= pending_words.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_word);
                    error_count++;
                end
                else
                begin
                    oldest_frame = expected_frames.pop_front();
                    if (out_word !== oldest_frame)
                    begin
                        $display("%0t: mismatch, expected v=%0d r=%0d g=%0d b=%0d",
                                 $time, oldest_frame.frame_valid, oldest_frame.red_level,
                                 oldest_frame.green_level, oldest_frame.blue_level);
                        $display("%0t:          actual   v=%0d r=%0d g=%0d b=%0d",
                                 $time, out_word.frame_valid, out_word.red_level,
                                 out_word.green_level, out_word.blue_level);
                        error_count++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic m, input logic [7:0] b);
        in_word_t w;
        w.mode    = m;
        w.rx_byte = b;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_word(MODE_BYTE, s[i]);
        end
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic int tick_span();
        return (idle_lim == 8'd0) ? 1 : int'(idle_lim);
    endfunction

    function automatic logic [7:0] run_char();
        if ($urandom_range(0, 9) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return DIGIT_BASE + 8'($urandom_range(0, 9));
    endfunction

    function automatic int run_len_pick();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 9)
        begin
            return 4;
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic push_run(input int len);
        repeat (len) push_word(MODE_BYTE, run_char());
    endtask

    // idle ticks inside a frame that stay short of ending it
    task automatic maybe_gap();
        if (idle_lim > 8'd1 && $urandom_range(0, 99) < 12)
        begin
            push_ticks($urandom_range(1, int'(idle_lim) - 1));
        end
    endtask

    task automatic push_random_frame();
        int kind;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4)) push_word(MODE_BYTE, 8'($urandom_range(0, 255)));
            push_ticks($urandom_range(0, 2));
        end
        push_word(MODE_BYTE, CHAR_R);
        if (kind < 70)
        begin
            push_run(run_len_pick());
            maybe_gap();
            if ($urandom_range(0, 99) >= 8)
            begin
                push_word(MODE_BYTE, CHAR_G);
            end
            push_run(run_len_pick());
            maybe_gap();
            if ($urandom_range(0, 99) >= 8)
            begin
                push_word(MODE_BYTE, CHAR_B);
            end
            push_run(run_len_pick());
            maybe_gap();
            if ($urandom_range(0, 99) >= 5)
            begin
                push_word(MODE_BYTE, CHAR_STAR);
            end
        end
        else if (kind < 96)
        begin
            repeat ($urandom_range(0, 12))
            begin
                case ($urandom_range(0, 6))
                    0: push_word(MODE_BYTE, CHAR_R);
                    1: push_word(MODE_BYTE, CHAR_G);
                    2: push_word(MODE_BYTE, CHAR_B);
                    3: push_word(MODE_BYTE, CHAR_STAR);
                    4: push_word(MODE_BYTE, 8'($urandom_range(0, 255)));
                    default: push_word(MODE_BYTE, run_char());
                endcase
                maybe_gap();
            end
        end
        else
        begin
            push_run($urandom_range(195, 215));
            push_word(MODE_BYTE, CHAR_STAR);
        end
        push_ticks(tick_span() + $urandom_range(0, 2));
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idle_ticks(input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        idle_lim = v;
    endtask

    task automatic run_phase(input logic [7:0] v, input int budget);
        int goal;
        wait_drained();
        set_idle_ticks(v);
        goal = words_queued + budget;
        while (words_queued < goal)
        begin
            push_random_frame();
        end
        push_ticks(tick_span());
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        // hunting: ignored bytes and ticks
        push_word(MODE_BYTE, 8'h00);
        push_word(MODE_BYTE, 8'hFF);
        push_word(MODE_TICK, 8'hFF);
        push_text("*G");
        // frame closed by the reset idle count
        push_text("R999G0B12*");
        push_ticks(tick_span());
        wait_drained();
        set_idle_ticks(8'd1);
        push_text("R1234G5B6*");
        push_ticks(1);
        push_text("RG7B*");
        push_ticks(1);
        push_text("R1G2B3");
        push_ticks(1);
        push_text("R*");
        push_ticks(1);
        push_text("RB5*");
        push_ticks(1);
        push_text("R");
        push_word(MODE_BYTE, 8'hFF);
        push_text("G");
        push_word(MODE_BYTE, 8'h00);
        push_text("B*");
        push_ticks(1);
        // overlong frame
        push_text("R12G3B");
        repeat (205) push_word(MODE_BYTE, CHAR_STAR);
        push_ticks(1);

        run_phase(8'd20, 130);
        run_phase(8'd1, 150);
        run_phase(8'd0, 130);
        run_phase(8'd255, 250);
        run_phase(8'd3, 120);
        run_phase(8'($urandom_range(2, 40)), 120);
        wait_drained();
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/arfp_pkg.sv
rtl/arfp_run_decode.sv
rtl/arfp_frame_core.sv
rtl/ascii_rgb_command_frame_parser_unit.sv
rtl/arfp_checker.sv
tb/tb_top.sv
